FILE: rtl/osm_pkg.sv
// Shared constants, register codes and helper functions for the overlapping substring matcher.
// Used by every module under rtl/; depends on nothing.
package osm_pkg;

    // Pattern storage in the configuration registers, in bytes
    localparam int CFG_BYTES     = 16;
    localparam int LINE_W        = 16;
    localparam int COL_W         = 16;
    localparam int LEN_W         = 5;
    localparam int LOC_W         = 2;
    localparam int CFG_ADDR_W    = 6;
    localparam int CFG_DATA_W    = 64;
    localparam int REG_IDX_W     = 3;
    localparam int QUEUE_DEPTH   = 2;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_PATTERN = 16;
    localparam int DEF_POS_BITS    = 16;

    // Register indexes (byte address = 8 * index)
    localparam logic [REG_IDX_W-1:0] REG_PAT_LO   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PAT_HI   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PAT_LEN  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_IGN_CASE = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LOCATION = 3'd4;

    // Search location codes
    localparam logic [LOC_W-1:0] LOC_BOTH  = 2'd0;
    localparam logic [LOC_W-1:0] LOC_LEFT  = 2'd1;
    localparam logic [LOC_W-1:0] LOC_RIGHT = 2'd2;

    // Lower ASCII capitals when case is ignored
    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic ign);
        logic [7:0] r;
        r = c;
        if (ign && (c >= 8'h41) && (c <= 8'h5A)) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    // Side 0 is the left file, side 1 the right file
    function automatic logic side_enabled(input logic side, input logic [LOC_W-1:0] loc);
        logic r;
        if (!side) begin
            r = (loc == LOC_BOTH) || (loc == LOC_LEFT);
        end else begin
            r = (loc == LOC_BOTH) || (loc == LOC_RIGHT);
        end
        return r;
    endfunction

endpackage

FILE: rtl/osm_front.sv
// Front end of the matcher: takes text items, keeps the line window and byte counter,
// and pushes a candidate hit into the queue. Depends on osm_pkg.
module osm_front
    import osm_pkg::*;
#(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN,
    parameter int POS_BITS    = DEF_POS_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [7:0]                 i_byte,
    input  logic                       i_side,
    input  logic [LINE_W-1:0]          i_line,
    input  logic                       i_begins,
    input  logic [CFG_BYTES-1:0][7:0]  i_pattern,
    input  logic [LEN_W-1:0]           i_len,
    input  logic                       i_ign_case,
    input  logic                       i_q_full,
    output logic                       o_q_push,
    output logic [1+LINE_W+POS_BITS-1:0] o_q_data
);

    localparam int CMP_N = (MAX_PATTERN < CFG_BYTES) ? MAX_PATTERN : CFG_BYTES;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    logic [MAX_PATTERN-1:0][7:0] r_win, n_win;
    logic [POS_BITS-1:0]         r_count, n_count;
    logic                        accept;
    logic                        len_ok, count_ok, bytes_eq, hit;
    logic [LEN_W-1:0]            pat_idx;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // Shift the newest byte in; a new line starts from an empty window
    always_comb begin
        n_win[0] = i_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            n_win[k] = i_begins ? 8'd0 : r_win[k-1];
        end
        if (i_begins) begin
            n_count = POS_BITS'(1);
        end else if (r_count == POS_MAX) begin
            n_count = r_count;
        end else begin
            n_count = r_count + POS_BITS'(1);
        end
    end

    // Window entry j lines up with pattern byte len-1-j
    always_comb begin
        bytes_eq = 1'b1;
        pat_idx  = '0;
        for (int j = 0; j < CMP_N; j++) begin
            pat_idx = i_len - LEN_W'(j + 1);
            if (j < int'(i_len)) begin
                if (fold_byte(n_win[j], i_ign_case) !=
                    fold_byte(i_pattern[pat_idx[3:0]], i_ign_case)) begin
                    bytes_eq = 1'b0;
                end
            end
        end
        len_ok   = (i_len != '0) && (int'(i_len) <= CFG_BYTES) && (int'(i_len) <= MAX_PATTERN);
        count_ok = n_count >= POS_BITS'(i_len);
        hit      = len_ok && count_ok && bytes_eq;
    end

    assign o_q_push = accept && hit;
    assign o_q_data = {n_count, i_line, i_side};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= '0;
            r_count <= '0;
        end else if (accept) begin
            r_win   <= n_win;
            r_count <= n_count;
        end
    end

endmodule

FILE: rtl/osm_queue.sv
// Short register queue that decouples the front end from the result stage.
// Depends on osm_pkg for the depth.
module osm_queue
    import osm_pkg::*;
#(
    parameter int WIDTH = 33
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [QUEUE_DEPTH-1:0][WIDTH-1:0] r_mem;
    logic [PTR_W-1:0]                  r_wr, r_rd;
    logic [CNT_W-1:0]                  r_cnt;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

FILE: rtl/osm_back.sv
// Result stage: applies the location filter, forms the hit column and holds
// the result in an output register. Depends on osm_pkg.
module osm_back
    import osm_pkg::*;
#(
    parameter int POS_BITS = DEF_POS_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  logic [1+LINE_W+POS_BITS-1:0] i_q_data,
    output logic                         o_q_pop,
    input  logic [LEN_W-1:0]             i_len,
    input  logic [LOC_W-1:0]             i_location,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_side,
    output logic [LINE_W-1:0]            o_line,
    output logic [COL_W-1:0]             o_column
);

    localparam int DIFF_W = (POS_BITS > COL_W) ? POS_BITS : COL_W;

    logic                r_valid, n_valid;
    logic                r_side;
    logic [LINE_W-1:0]   r_line;
    logic [COL_W-1:0]    r_column;
    logic                q_side, en, load;
    logic [LINE_W-1:0]   q_line;
    logic [POS_BITS-1:0] q_count;
    logic [DIFF_W-1:0]   diff;

    assign q_side  = i_q_data[0];
    assign q_line  = i_q_data[LINE_W:1];
    assign q_count = i_q_data[1+LINE_W+POS_BITS-1:1+LINE_W];
    assign en      = side_enabled(q_side, i_location);
    assign diff    = DIFF_W'(q_count) - DIFF_W'(i_len);

    // Drop filtered entries at once; keep a hit only when the output slot frees up
    assign o_q_pop = i_q_valid && (!en || !r_valid || i_ready);
    assign load    = o_q_pop && en;

    always_comb begin
        n_valid = r_valid;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        if (load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_side   <= q_side;
            r_line   <= q_line;
            r_column <= diff[COL_W-1:0];
        end
    end

    assign o_valid  = r_valid;
    assign o_side   = r_side;
    assign o_line   = r_line;
    assign o_column = r_column;

endmodule

FILE: rtl/overlapping_substring_matcher.sv
// Top level of the overlapping substring matcher: configuration registers, front end,
// hit queue and result stage. Depends on osm_pkg, osm_front, osm_queue, osm_back.
//
//   channel   direction  payload
//   s_axis    in         tdata {line_number, text_byte}, tuser {line_begins, file_side}
//   m_axis    out        tdata {hit_column, hit_line}, tuser {hit_side}
//   apb       in/out     pattern_lo 0x00, pattern_hi 0x08, length 0x10, case 0x18, loc 0x20
//
// One text item is accepted every cycle while the two-entry hit queue has room.
// A hit passes through the hit queue and then the result register before it appears on m_axis.
// Reset is synchronous and clears the window, counter, queue, result valid flag and registers.
// A stalled m_axis fills the queue, after which s_axis_tready drops.
module overlapping_substring_matcher
    import osm_pkg::*;
#(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN,
    parameter int POS_BITS    = DEF_POS_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,  // text_byte[7:0], line_number[23:8]
    input  logic [1:0]            s_axis_tuser,  // file_side[0], line_begins[1]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,  // hit_line[15:0], hit_column[31:16]
    output logic [0:0]            m_axis_tuser,  // hit_side[0]
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int Q_W = 1 + LINE_W + POS_BITS;

    logic [CFG_DATA_W-1:0] r_pat_lo, r_pat_hi;
    logic [LEN_W-1:0]      r_len;
    logic                  r_ign_case;
    logic [LOC_W-1:0]      r_location;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  cfg_wr;

    logic                  q_push, q_full, q_pop, q_valid;
    logic [Q_W-1:0]        q_wdata, q_rdata;
    logic                  hit_side;
    logic [LINE_W-1:0]     hit_line;
    logic [COL_W-1:0]      hit_column;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_W-1:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo   <= '0;
            r_pat_hi   <= '0;
            r_len      <= '0;
            r_ign_case <= 1'b0;
            r_location <= LOC_BOTH;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_PAT_LO:   r_pat_lo   <= pwdata;
                REG_PAT_HI:   r_pat_hi   <= pwdata;
                REG_PAT_LEN:  r_len      <= pwdata[LEN_W-1:0];
                REG_IGN_CASE: r_ign_case <= pwdata[0];
                REG_LOCATION: r_location <= pwdata[LOC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PAT_LO:   prdata = r_pat_lo;
            REG_PAT_HI:   prdata = r_pat_hi;
            REG_PAT_LEN:  prdata = CFG_DATA_W'(r_len);
            REG_IGN_CASE: prdata = CFG_DATA_W'(r_ign_case);
            REG_LOCATION: prdata = CFG_DATA_W'(r_location);
            default:      prdata = '0;
        endcase
    end

    osm_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .POS_BITS    (POS_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_byte     (s_axis_tdata[7:0]),
        .i_side     (s_axis_tuser[0]),
        .i_line     (s_axis_tdata[23:8]),
        .i_begins   (s_axis_tuser[1]),
        .i_pattern  ({r_pat_hi, r_pat_lo}),
        .i_len      (r_len),
        .i_ign_case (r_ign_case),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_wdata)
    );

    osm_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    osm_back #(
        .POS_BITS (POS_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_data   (q_rdata),
        .o_q_pop    (q_pop),
        .i_len      (r_len),
        .i_location (r_location),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_side     (hit_side),
        .o_line     (hit_line),
        .o_column   (hit_column)
    );

    assign m_axis_tdata = {hit_column, hit_line};
    assign m_axis_tuser = hit_side;

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("hit pushed into a full queue");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("pop from an empty queue");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

FILE: tb/osm_hit_checker.sv
`timescale 1ns / 100ps
// Hit checker for the overlapping substring matcher: tracks APB writes, predicts hits from
// accepted text items and compares them with the m_axis results. Depends on osm_pkg.
module osm_hit_checker
    import osm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [23:0]           i_s_tdata,   // text_byte[7:0], line_number[23:8]
    input  logic [1:0]            i_s_tuser,   // file_side[0], line_begins[1]
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [31:0]           i_m_tdata,   // hit_line[15:0], hit_column[31:16]
    input  logic [0:0]            i_m_tuser,   // hit_side[0]
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [CFG_ADDR_W-1:0] i_paddr,
    input  logic [CFG_DATA_W-1:0] i_pwdata,
    output int                    o_mismatches,
    output int                    o_pending,
    output int                    o_hits
);

    typedef struct packed {
        logic              side;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  column;
    } t_hit;

    t_hit                        expected_hits[$];
    logic [2*CFG_DATA_W-1:0]     pattern;
    logic [LEN_W-1:0]            pattern_len;
    logic                        nocase;
    logic [LOC_W-1:0]            search_loc;
    logic [7:0]                  window [0:DEF_MAX_PATTERN-1];
    logic [DEF_POS_BITS-1:0]     line_fill;
    int                          mismatch_cnt;
    int                          hit_cnt;

    function automatic logic [7:0] lower_case(input logic [7:0] c, input logic on);
        logic [7:0] r;
        r = c;
        if (on && c >= 8'h41 && c <= 8'h5A) begin
            r = c | 8'h20;
        end
        return r;
    endfunction

    // Shift one text item into the window and queue the hit it completes, if any
    task automatic take_text(input logic [7:0] b, input logic side, input logic [15:0] line,
                             input logic begins);
        logic enabled;
        logic found;
        t_hit h;
        if (begins) begin
            for (int i = 0; i < DEF_MAX_PATTERN; i++) window[i] = 8'h00;
            line_fill = '0;
        end
        for (int i = DEF_MAX_PATTERN - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = b;
        if (line_fill != '1) line_fill = line_fill + 1'b1;

        if (side) begin
            enabled = (search_loc == LOC_BOTH) || (search_loc == LOC_RIGHT);
        end else begin
            enabled = (search_loc == LOC_BOTH) || (search_loc == LOC_LEFT);
        end
        if (!enabled || pattern_len == 0 || pattern_len > CFG_BYTES ||
            pattern_len > DEF_MAX_PATTERN || line_fill < pattern_len) begin
            return;
        end
        found = 1'b1;
        for (int i = 0; i < pattern_len; i++) begin
            if (lower_case(window[pattern_len-1-i], nocase) !=
                lower_case(pattern[8*i +: 8], nocase)) begin
                found = 1'b0;
            end
        end
        if (found) begin
            h.side   = side;
            h.line   = line;
            h.column = line_fill - pattern_len;
            expected_hits = {expected_hits, h};
        end
    endtask

    task automatic check_hit(input t_hit got);
        t_hit want;
        hit_cnt++;
        if (expected_hits.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
                $display("%0t: unexpected hit side %0d line %0d column %0d",
                         $realtime, got.side, got.line, got.column);
            end
            return;
        end
        want = expected_hits.pop_front();
        if (got != want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
                $display("%0t: expected side %0d line %0d col %0d, got %0d %0d %0d",
                         $realtime, want.side, want.line, want.column,
                         got.side, got.line, got.column);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_hits.delete();
            pattern      = '0;
            pattern_len  = '0;
            nocase       = 1'b0;
            search_loc   = LOC_BOTH;
            line_fill    = '0;
            for (int i = 0; i < DEF_MAX_PATTERN; i++) window[i] = 8'h00;
            mismatch_cnt = 0;
            hit_cnt      = 0;
        end else begin
            // no hit can leave in the cycle its item enters, so order here is free
            if (i_m_tvalid && i_m_tready) begin
                check_hit({i_m_tuser[0], i_m_tdata[15:0], i_m_tdata[31:16]});
            end
            if (i_s_tvalid && i_s_tready) begin
                take_text(i_s_tdata[7:0], i_s_tuser[0], i_s_tdata[23:8], i_s_tuser[1]);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[CFG_ADDR_W-1:3])
                    REG_PAT_LO:   pattern[CFG_DATA_W-1:0]            = i_pwdata;
                    REG_PAT_HI:   pattern[2*CFG_DATA_W-1:CFG_DATA_W] = i_pwdata;
                    REG_PAT_LEN:  pattern_len = i_pwdata[LEN_W-1:0];
                    REG_IGN_CASE: nocase      = i_pwdata[0];
                    REG_LOCATION: search_loc  = i_pwdata[LOC_W-1:0];
                    default: ;
                endcase
            end
        end
        o_mismatches <= mismatch_cnt;
        o_pending    <= expected_hits.size();
        o_hits       <= hit_cnt;
    end

endmodule

FILE: tb/overlapping_substring_matcher_tb.sv
`timescale 1ns / 100ps
// Testbench top for the overlapping substring matcher: clock, reset, APB setup, text stream
// and hit sink. Depends on osm_pkg, overlapping_substring_matcher and osm_hit_checker.
module overlapping_substring_matcher_tb;
    import osm_pkg::*;

    localparam int HOLD_CYCLES    = 120;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETS           = 12;
    localparam int ITEMS_PER_SET  = 150;
    localparam logic [LOC_W-1:0] LOC_NONE = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata = '0;  // text_byte[7:0], line_number[23:8]
    logic [1:0]            s_axis_tuser = '0;  // file_side[0], line_begins[1]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;       // hit_line[15:0], hit_column[31:16]
    logic [0:0]            m_axis_tuser;       // hit_side[0]
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatches, pending, hits;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int items_sent = 0;
    int settings_used = 0;

    logic [2*CFG_DATA_W-1:0] cur_pattern = '0;
    logic [LEN_W-1:0]        cur_len = '0;

    overlapping_substring_matcher DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    osm_hit_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tuser(s_axis_tuser),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata), .i_m_tuser(m_axis_tuser),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_mismatches(mismatches), .o_pending(pending), .o_hits(hits)
    );

    always #10 i_clk = ~i_clk;

    // Hit sink: random stalls, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            holds_served  <= 0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (holds_served != hold_requests) begin
            m_axis_tready <= 1'b0;
            holds_served  <= holds_served + 1;
            hold_left     <= HOLD_CYCLES;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_text(input logic [7:0] b, input logic side, input logic [15:0] line,
                             input logic begins);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {line, b};
        s_axis_tuser  <= {begins, side};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // Leave the bus selected; the caller releases it after the last write
    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    // Drop valid, wait for every predicted hit, then let the pipeline drain
    task automatic go_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_matcher(input logic [63:0] lo, input logic [63:0] hi,
                                   input logic [LEN_W-1:0] len, input logic nocase,
                                   input logic [LOC_W-1:0] loc);
        go_idle();
        apb_write(REG_PAT_LO, lo);
        apb_write(REG_PAT_HI, hi);
        apb_write(REG_PAT_LEN, CFG_DATA_W'(len));
        apb_write(REG_IGN_CASE, CFG_DATA_W'(nocase));
        apb_write(REG_LOCATION, CFG_DATA_W'(loc));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_pattern = {hi, lo};
        cur_len     = len;
        settings_used++;
    endtask

    function automatic logic [7:0] pick_letter();
        logic [7:0] letters [4] = '{8'h61, 8'h62, 8'h41, 8'h42};
        return letters[$urandom_range(3)];
    endfunction

    function automatic logic [63:0] random_pattern_word();
        logic [63:0] w;
        int r;
        for (int i = 0; i < 8; i++) begin
            r = $urandom_range(99);
            if (r < 85)      w[8*i +: 8] = pick_letter();
            else if (r < 95) w[8*i +: 8] = 8'($urandom_range(255));
            else             w[8*i +: 8] = r[0] ? 8'hFF : 8'h00;
        end
        return w;
    endfunction

    // Lines whose bytes mostly walk through the pattern, with case flips and noise
    task automatic stream_lines(input int count);
        int sent;
        int run;
        int follow_pct;
        int span;
        int idx;
        int r;
        logic [7:0]  b;
        logic        side;
        logic [15:0] line;
        logic        begins;
        sent = 0;
        span = (cur_len >= 1 && cur_len <= CFG_BYTES) ? int'(cur_len) : 4;
        follow_pct = (span > 8) ? 95 : 55;
        while (sent < count) begin
            run    = $urandom_range(1, (span > 8) ? 60 : 40);
            side   = $urandom_range(1);
            line   = $urandom;
            begins = ($urandom_range(99) < 92);
            idx    = 0;
            for (int n = 0; n < run && sent < count; n++) begin
                r = $urandom_range(99);
                if (r < follow_pct) begin
                    b   = cur_pattern[8*idx +: 8];
                    idx = (idx + 1) % span;
                    if ((b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A &&
                        $urandom_range(99) < 20) begin
                        b = b ^ 8'h20;
                    end
                end else if (r < 92) begin
                    b = pick_letter();
                end else begin
                    b = 8'($urandom_range(255));
                end
                // move to another line or side without a line start now and then
                if ($urandom_range(99) < 3) begin
                    if ($urandom_range(1)) side = ~side;
                    else line = $urandom;
                end
                send_text(b, side, line, begins && n == 0);
                sent++;
            end
        end
    endtask

    function automatic logic [LOC_W-1:0] location_for(input int k);
        case ((k + 1) % 4)
            0:       return LOC_BOTH;
            1:       return LOC_LEFT;
            2:       return LOC_RIGHT;
            default: return LOC_NONE;
        endcase
    endfunction

    initial begin
        logic [63:0]      lo;
        logic [63:0]      hi;
        logic [LEN_W-1:0] len;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: case folding, side/line change mid-line, new line clearing
        program_matcher(64'h4261, 64'h0, 5'd2, 1'b1, LOC_BOTH);
        send_text(8'h61, 1'b0, 16'h0000, 1'b1);
        send_text(8'h62, 1'b0, 16'h0000, 1'b0);
        send_text(8'h61, 1'b1, 16'hFFFF, 1'b0);
        send_text(8'h42, 1'b1, 16'hFFFF, 1'b0);
        send_text(8'h62, 1'b0, 16'h0001, 1'b1);
        send_text(8'hFF, 1'b0, 16'h0001, 1'b0);
        send_text(8'h00, 1'b0, 16'h0001, 1'b0);
        send_text(8'h01, 1'b1, 16'h0001, 1'b0);

        // NUL bytes in the pattern; a short line must not match the cleared window
        program_matcher(64'h78_0000, '1, 5'd3, 1'b0, LOC_LEFT);
        send_text(8'h78, 1'b0, 16'h0002, 1'b1);
        send_text(8'h00, 1'b0, 16'h0002, 1'b0);
        send_text(8'h00, 1'b0, 16'h0002, 1'b0);
        send_text(8'h78, 1'b0, 16'h0002, 1'b0);
        send_text(8'h00, 1'b1, 16'h0002, 1'b0);
        send_text(8'h00, 1'b1, 16'h0002, 1'b0);
        send_text(8'h78, 1'b1, 16'h0002, 1'b0);

        // Folding boundaries and the location modes
        program_matcher(64'h7A, 64'h0, 5'd1, 1'b1, LOC_RIGHT);
        send_text(8'h5A, 1'b1, 16'h0003, 1'b1);
        send_text(8'h7A, 1'b0, 16'h0003, 1'b0);
        send_text(8'h40, 1'b1, 16'h0003, 1'b0);
        program_matcher(64'h60, 64'h0, 5'd1, 1'b1, LOC_NONE);
        send_text(8'h40, 1'b0, 16'h0004, 1'b1);
        send_text(8'h60, 1'b1, 16'h0004, 1'b0);
        send_text(8'h60, 1'b0, 16'h0004, 1'b0);

        // Random sets: sender/receiver stall phases, then full speed with long hold-offs
        for (int k = 0; k < SETS; k++) begin
            if (k == 0) begin
                tx_idle_pct  = 22;
                rx_idle_pct <= 49;
            end else if (k == 4) begin
                tx_idle_pct  = 49;
                rx_idle_pct <= 22;
            end else if (k == 8) begin
                tx_idle_pct  = 0;
                rx_idle_pct <= 0;
            end
            lo = random_pattern_word();
            hi = random_pattern_word();
            if (k == 1) begin
                lo = '1;
                hi = '1;
            end else if (k == 5) begin
                lo = '0;
                hi = '0;
            end
            case (k)
                3:       len = 5'd16;
                7:       len = 5'd0;
                8:       len = 5'd1;
                10:      len = 5'd31;
                11:      len = LEN_W'($urandom_range(17, 30));
                default: len = LEN_W'($urandom_range(1, 6));
            endcase
            program_matcher(lo, hi, len, 1'((k / 2) % 2), location_for(k));
            if (k == 8 || k == 9) hold_requests <= hold_requests + 1;
            stream_lines(ITEMS_PER_SET);
        end

        go_idle();
        $display("Run covered %0d text items and %0d hits over %0d register settings,",
                 items_sent, hits, settings_used);
        $display("including case folding, NUL bytes, location modes and long output hold-offs.");
        if (mismatches == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches, %0d hits still expected", mismatches, pending);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
